// ----- rtl/spq_pkg.sv -----
// Shared types and codes for the sorted priority queue.
package spq_pkg;

  localparam logic CMD_INSERT = 1'b0;
  localparam logic CMD_REMOVE = 1'b1;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_OVERFLOW  = 2'd1;
  localparam logic [1:0] ST_UNDERFLOW = 2'd2;

  typedef struct packed {
    logic               command;
    logic signed [31:0] item_value;
    logic        [7:0]  priority_req;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] removed_value;
    logic        [1:0]  status;
  } out_item_t;

  typedef struct packed {
    logic signed [31:0] value;
    logic        [7:0]  prio;
  } entry_t;

  // What a cell shows its neighbors.
  typedef struct packed {
    logic   valid;
    logic   keep;
    entry_t ent;
  } cell_link_t;

  // Operation broadcast to every cell in the same cycle.
  typedef struct packed {
    logic   ins;
    logic   rem;
    entry_t ent;
  } cell_op_t;

endpackage

// ----- rtl/spq_cell.sv -----
// One slot of the sorted queue: holds an entry and moves it along the row.
module spq_cell (
  input  logic               clk,
  input  logic               rst_n,
  input  spq_pkg::cell_op_t   op,
  input  spq_pkg::cell_link_t left_in,
  input  spq_pkg::cell_link_t right_in,
  output spq_pkg::cell_link_t link_out
);

  logic           valid_r;
  logic           valid_nxt;
  spq_pkg::entry_t ent_r;
  spq_pkg::entry_t ent_nxt;
  logic           keep;

  // An entry stays put on insert when its priority is not above the new one.
  assign keep = valid_r && (ent_r.prio <= op.ent.prio);

  assign link_out.valid = valid_r;
  assign link_out.keep  = keep;
  assign link_out.ent   = ent_r;

  always_comb begin
    valid_nxt = valid_r;
    ent_nxt   = ent_r;
    priority if (op.rem) begin
      valid_nxt = right_in.valid;
      ent_nxt   = right_in.ent;
    end else if (op.ins) begin
      priority if (keep) begin
        valid_nxt = valid_r;
      end else if (left_in.valid && !left_in.keep) begin
        valid_nxt = 1'b1;
        ent_nxt   = left_in.ent;
      end else if (left_in.keep) begin
        valid_nxt = 1'b1;
        ent_nxt   = op.ent;
      end else begin
        valid_nxt = valid_r;
      end
    end else begin
      valid_nxt = valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
    ent_r <= ent_nxt;
  end

endmodule

// ----- rtl/sorted_priority_queue.sv -----
// Top level of the sorted priority queue: a row of shifting cells and a result register.
//
// Each input transfer on in_data is either an insert (value and priority number) or a
// remove. Every input transfer yields exactly one result transfer on out_data.
// The queue holds up to SLOTS-1 entries, kept sorted by ascending priority number in a
// row of cells; cell 0 always holds the entry that leaves next. Equal priority numbers
// leave in arrival order, because an insert lands behind every entry whose priority
// number is less than or equal to its own.
// An insert into a full queue reports overflow and a remove from an empty queue reports
// underflow; both leave the contents unchanged and return a removed value of zero.
// Timing: every cell compares against the new entry and shifts toward or away from its
// neighbor in the same cycle, so one item is taken per cycle while the receiver keeps up,
// and its result appears in the output register in the cycle after the input transfer.
// When the receiver stalls, the result waits in the output register and in_ready drops
// until it is taken; an item is accepted in the same cycle that a result is taken.
// After reset (rst_n low, synchronous) the queue is empty and no result is pending.
module sorted_priority_queue #(
  parameter int SLOTS = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  spq_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output spq_pkg::out_item_t out_data
);

  localparam int NCELLS = SLOTS - 1;

  spq_pkg::cell_link_t link [NCELLS];
  spq_pkg::cell_op_t   op;
  spq_pkg::cell_link_t head_left;
  spq_pkg::cell_link_t tail_right;

  logic               out_valid_r;
  spq_pkg::out_item_t out_r;
  spq_pkg::out_item_t out_nxt;
  logic               take;
  logic               full;
  logic               empty;

  // The row is full when its last cell is occupied and empty when its first is not.
  assign full  = link[NCELLS-1].valid;
  assign empty = !link[0].valid;

  // A new item is taken whenever the result register is free or being emptied.
  assign in_ready = !out_valid_r || out_ready;
  assign take     = in_valid && in_ready;

  assign op.ins           = take && (in_data.command == spq_pkg::CMD_INSERT) && !full;
  assign op.rem           = take && (in_data.command == spq_pkg::CMD_REMOVE) && !empty;
  assign op.ent.value     = in_data.item_value;
  assign op.ent.prio      = in_data.priority_req;

  // Ahead of cell 0 sits a virtual entry that always stays, so cell 0 takes the new
  // entry whenever its own entry moves back. Behind the last cell nothing is valid.
  assign head_left.valid  = 1'b1;
  assign head_left.keep   = 1'b1;
  assign head_left.ent    = '0;
  assign tail_right.valid = 1'b0;
  assign tail_right.keep  = 1'b0;
  assign tail_right.ent   = '0;

  for (genvar i = 0; i < NCELLS; i++) begin : g_cell
    spq_pkg::cell_link_t left_sel;
    spq_pkg::cell_link_t right_sel;
    if (i == 0) begin : g_first
      assign left_sel = head_left;
    end else begin : g_mid_l
      assign left_sel = link[i-1];
    end
    if (i == NCELLS - 1) begin : g_last
      assign right_sel = tail_right;
    end else begin : g_mid_r
      assign right_sel = link[i+1];
    end
    spq_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .op       (op),
      .left_in  (left_sel),
      .right_in (right_sel),
      .link_out (link[i])
    );
  end

  // Result of the item taken in this cycle; cell 0 holds the entry a remove returns.
  always_comb begin
    out_nxt.removed_value = '0;
    out_nxt.status        = spq_pkg::ST_OK;
    unique case (in_data.command)
      spq_pkg::CMD_INSERT: begin
        if (full) begin
          out_nxt.status = spq_pkg::ST_OVERFLOW;
        end
      end
      spq_pkg::CMD_REMOVE: begin
        if (empty) begin
          out_nxt.status = spq_pkg::ST_UNDERFLOW;
        end else begin
          out_nxt.removed_value = link[0].ent.value;
        end
      end
      default: begin
        out_nxt.status = spq_pkg::ST_OK;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (take) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
    if (take) begin
      out_r <= out_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

// ----- bench/spq_result_checker.sv -----
`timescale 1ns / 100ps
// Result checker for the sorted priority queue: tracks its contents and compares every result.
module spq_result_checker #(
  parameter int SLOTS = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_ready,
  input  spq_pkg::in_item_t  in_data,
  input  logic               out_valid,
  input  logic               out_ready,
  input  spq_pkg::out_item_t out_data,
  output int                 mismatches,
  output int                 outstanding,
  output int                 insert_count,
  output int                 remove_count,
  output int                 overflow_count,
  output int                 underflow_count
);

  // Stored entries, front first, and the results still owed by the block.
  spq_pkg::entry_t    queued_entries[$];
  spq_pkg::out_item_t pending_results[$];

  function automatic spq_pkg::out_item_t predict_response(input spq_pkg::in_item_t it);
    spq_pkg::out_item_t resp;
    spq_pkg::entry_t    e;
    int                 pos;
    resp.removed_value = '0;
    resp.status        = spq_pkg::ST_OK;
    if (it.command == spq_pkg::CMD_INSERT) begin
      insert_count++;
      if (queued_entries.size() >= SLOTS - 1) begin
        resp.status = spq_pkg::ST_OVERFLOW;
        overflow_count++;
      end else begin
        // The new entry goes behind every entry whose priority number is not above its own.
        pos = queued_entries.size();
        while (pos > 0 && queued_entries[pos-1].prio > it.priority_req) pos--;
        e.value = it.item_value;
        e.prio  = it.priority_req;
        queued_entries.insert(pos, e);
      end
    end else begin
      remove_count++;
      if (queued_entries.size() == 0) begin
        resp.status = spq_pkg::ST_UNDERFLOW;
        underflow_count++;
      end else begin
        e = queued_entries.pop_front();
        resp.removed_value = e.value;
      end
    end
    return resp;
  endfunction

  always @(posedge clk) begin : watch
    spq_pkg::out_item_t want;
    if (rst_n) begin
      if (in_valid && in_ready) pending_results.push_back(predict_response(in_data));
      if (out_valid && out_ready) begin
        if (pending_results.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: unexpected result: value %0d status %0d", $time,
                     out_data.removed_value, out_data.status);
        end else begin
          want = pending_results.pop_front();
          if (out_data.removed_value !== want.removed_value ||
              out_data.status !== want.status) begin
            mismatches++;
            if (mismatches <= 10)
              $display({"%0t: result mismatch: expected value %0d status %0d, ",
                        "got value %0d status %0d"},
                       $time, want.removed_value, want.status,
                       out_data.removed_value, out_data.status);
          end
        end
      end
    end
    outstanding <= pending_results.size();
  end

endmodule

// ----- bench/sorted_priority_queue_tb.sv -----
`timescale 1ns / 100ps
// Testbench top for the sorted priority queue: clock, reset, stimulus and verdict.
module sorted_priority_queue_tb;

  localparam int SLOTS       = 16;
  localparam int PHASE_ITEMS = 181;
  // The limit leaves a wide margin over the slowest legal run.
  localparam int CYCLE_LIMIT = 200000;
  // The block answers in the cycle after a transfer, so a short quiet spell is plenty.
  localparam int DRAIN_WAIT  = 20;

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_ready;
  spq_pkg::in_item_t  in_data;
  logic               out_valid;
  logic               out_ready;
  spq_pkg::out_item_t out_data;

  // Percent chance per cycle that the sender holds back or the receiver stalls.
  int sender_idle;
  int receiver_stall;
  int cycle_count;

  int mismatches;
  int outstanding;
  int insert_count;
  int remove_count;
  int overflow_count;
  int underflow_count;

  sorted_priority_queue #(
    .SLOTS(SLOTS)
  ) u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  // The checker sits beside the block, sees every transfer on both channels and keeps
  // its own picture of the queue contents.
  spq_result_checker #(
    .SLOTS(SLOTS)
  ) u_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_data        (in_data),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_data       (out_data),
    .mismatches     (mismatches),
    .outstanding    (outstanding),
    .insert_count   (insert_count),
    .remove_count   (remove_count),
    .overflow_count (overflow_count),
    .underflow_count(underflow_count)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Guard against a hung handshake: the run is cut off well past any legal length.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Timed out after %0d cycles with %0d results outstanding",
               cycle_count, outstanding);
      $display("FAIL");
      $finish;
    end
  end

  // The receiver draws a fresh ready every cycle, so stalls land on every phase of the
  // block's work, including the cycle right after an input transfer.
  initial begin
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      out_ready <= ($urandom_range(99) >= receiver_stall);
    end
  end

  function automatic spq_pkg::in_item_t make_insert(input logic signed [31:0] value,
                                                    input logic [7:0] prio);
    spq_pkg::in_item_t it;
    it.command      = spq_pkg::CMD_INSERT;
    it.item_value   = value;
    it.priority_req = prio;
    return it;
  endfunction

  // A remove carries random junk in its ignored fields, since the block must not look
  // at them.
  function automatic spq_pkg::in_item_t make_remove();
    spq_pkg::in_item_t it;
    it.command      = spq_pkg::CMD_REMOVE;
    it.item_value   = $urandom;
    it.priority_req = 8'($urandom_range(255));
    return it;
  endfunction

  // Random traffic: values lean toward the extremes now and then, and half of the priority
  // numbers come from a narrow band so that ties, which must leave in arrival order,
  // are common.
  function automatic spq_pkg::in_item_t random_item(input int insert_pct);
    spq_pkg::in_item_t it;
    it.command = ($urandom_range(99) < insert_pct) ? spq_pkg::CMD_INSERT
                                                     : spq_pkg::CMD_REMOVE;
    case ($urandom_range(7))
      0: it.item_value = 32'sh7fff_ffff;
      1: it.item_value = 32'sh8000_0000;
      2: it.item_value = -32'sd1;
      default: it.item_value = $urandom;
    endcase
    case ($urandom_range(3))
      0: it.priority_req = 8'($urandom_range(255));
      1: it.priority_req = $urandom_range(1) ? 8'd255 : 8'd0;
      default: it.priority_req = 8'($urandom_range(3));
    endcase
    return it;
  endfunction

  // Presents one item and returns at the edge where it is transferred. Valid is only
  // lowered when an idle gap is taken, so back-to-back items keep it high throughout.
  task automatic push_item(input spq_pkg::in_item_t it);
    if ($urandom_range(99) < sender_idle) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < sender_idle);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (!in_ready);
  endtask

  initial begin : stimulus
    int phase;
    int sent;
    int burst;
    int insert_pct;

    sender_idle    = 0;
    receiver_stall = 0;
    rst_n    <= 1'b0;
    in_valid <= 1'b0;
    in_data  <= '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part. A remove on the empty queue must report underflow.
    push_item(make_remove());
    // Fill the queue with the value extremes, both priority extremes and ties at the
    // low, middle and high end of the priority range.
    push_item(make_insert(32'sh7fff_ffff, 8'd255));
    push_item(make_insert(32'sh8000_0000, 8'd0));
    push_item(make_insert(32'sd0, 8'd128));
    push_item(make_insert(-32'sd1, 8'd128));
    push_item(make_insert(32'sd5, 8'd128));
    push_item(make_insert(32'sd1, 8'd255));
    push_item(make_insert(32'sd2, 8'd0));
    push_item(make_insert(32'sd3, 8'd7));
    push_item(make_insert(32'sd4, 8'd200));
    push_item(make_insert(32'sd6, 8'd1));
    push_item(make_insert(32'sd7, 8'd254));
    push_item(make_insert(32'sd8, 8'd128));
    push_item(make_insert(32'sd9, 8'd64));
    push_item(make_insert(32'sd10, 8'd32));
    push_item(make_insert(32'sd11, 8'd16));
    // The queue now holds its full capacity, so this insert must be refused.
    push_item(make_insert(32'sd12, 8'd0));
    // Take out the front half; the rest stays for the random part to build on.
    repeat (8) push_item(make_remove());

    // Random part in four idling phases. Each burst picks at random among filling,
    // balanced and draining mixes so the queue keeps swinging between full and empty.
    for (phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin
          sender_idle    = 0;
          receiver_stall = 0;
        end
        1: begin
          sender_idle    = 74;
          receiver_stall = 0;
        end
        2: begin
          sender_idle    = 0;
          receiver_stall = 74;
        end
        default: begin
          sender_idle    = 10;
          receiver_stall = 10;
        end
      endcase
      sent = 0;
      while (sent < PHASE_ITEMS) begin
        burst = $urandom_range(40, 12);
        case ($urandom_range(2))
          0: insert_pct = 85;
          1: insert_pct = 50;
          default: insert_pct = 20;
        endcase
        repeat (burst) begin
          if (sent < PHASE_ITEMS) begin
            push_item(random_item(insert_pct));
            sent++;
          end
        end
      end
    end

    // Drop valid at the edge of the last transfer so that item is not taken twice.
    // The checker's count of owed results already includes it by the next edge.
    in_valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
    // Any stray result after the last expected one shows up as a mismatch here.
    repeat (DRAIN_WAIT) @(posedge clk);

    $display("Covered %0d inserts (%0d refused on a full queue) and %0d removes",
             insert_count, overflow_count, remove_count);
    $display("(%0d on an empty queue) under no idling, sender gaps, receiver stalls and both.",
             underflow_count);
    $display("%0d mismatches in %0d cycles.", mismatches, cycle_count);
    if (mismatches == 0 && outstanding == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/spq_pkg.sv
rtl/spq_cell.sv
rtl/sorted_priority_queue.sv
bench/spq_result_checker.sv
bench/sorted_priority_queue_tb.sv
